FILE: src/mmlsed_pkg.sv
// shared types, opcodes and event codes of the sequence event decoder
package mmlsed_pkg;

  localparam logic [7:0] OP_END      = 8'hFF;
  localparam logic [7:0] OP_GATE     = 8'hF2;
  localparam logic [7:0] OP_DEFLEN   = 8'hF3;
  localparam logic [7:0] OP_TEMPO    = 8'hF4;
  localparam logic [7:0] OP_TONE     = 8'hF5;
  localparam logic [7:0] OP_VOLUME   = 8'hF9;
  localparam logic [7:0] OP_REPEAT   = 8'hF8;
  localparam logic [7:0] OP_SKIP2_A  = 8'hF1;
  localparam logic [7:0] OP_SKIP2_B  = 8'hFB;
  localparam logic [7:0] OP_SKIP3_A  = 8'hF6;
  localparam logic [7:0] OP_SKIP3_B  = 8'hFE;
  localparam logic [7:0] OP_SKIP1_A  = 8'hF7;
  localparam logic [7:0] OP_SKIP1_B  = 8'hFA;
  localparam logic [7:0] OP_SKIP1_C  = 8'hFC;
  localparam logic [7:0] OP_SKIP1_D  = 8'hFD;

  localparam logic [7:0] KEY_MAX      = 8'h60;
  localparam logic [7:0] KEY_REST     = 8'h70;
  localparam logic [6:0] KEY_REST7    = 7'h70;
  localparam logic [7:0] FULL_LO      = 8'h80;
  localparam logic [7:0] FULL_HI      = 8'hE0;
  localparam logic [7:0] GATE_RESET   = 8'd8;
  localparam logic [7:0] DEFLEN_RESET = 8'd48;
  localparam logic [31:0] TICKS_MAX   = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_SKIP = 4'b0010,
    PH_ARG  = 4'b0100,
    PH_LEN  = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    EV_PASS = 2'd0,
    EV_REST = 2'd1,
    EV_NOTE = 2'd2,
    EV_END  = 2'd3
  } event_kind_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  command_code;
    logic [7:0]  value_byte;
    logic [7:0]  length_total;
    logic [7:0]  length_on;
    logic [7:0]  length_off;
    logic [31:0] stream_ticks;
    logic        stream_silent;
  } result_t;

endpackage

FILE: src/mml_sequence_event_decoder.sv
// top level: input register, decode core and result register
//
//   channel   handshake                   payload
//   stream    stream_valid/stream_ready   stream_byte
//   event     event_valid/event_ready     event_kind .. stream_silent
//
// one byte per cycle while no result waits unread: a byte sits in the input
// register while the core decodes it, and any result it yields is captured in
// the result register as the byte leaves the input register, raising event_valid
// the input register keeps taking bytes while a result waits, until it fills
// synchronous reset returns the parser to idle with gate 8 and length 48
module mml_sequence_event_decoder import mmlsed_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        stream_valid,
  output logic        stream_ready,
  input  logic [7:0]  stream_byte,
  output logic        event_valid,
  input  logic        event_ready,
  output logic [1:0]  event_kind,
  output logic [7:0]  command_code,
  output logic [7:0]  value_byte,
  output logic [7:0]  length_total,
  output logic [7:0]  length_on,
  output logic [7:0]  length_off,
  output logic [31:0] stream_ticks,
  output logic        stream_silent
);

  logic       in_full;
  logic [7:0] in_byte;
  logic       advance;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  assign advance      = in_full && (!event_valid || event_ready);
  assign stream_ready = !in_full || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (stream_ready) begin
      in_full <= stream_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream_valid && stream_ready) begin
      in_byte <= stream_byte;
    end
  end

  mmlsed_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (advance),
    .item_byte  (in_byte),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (advance && res_valid) begin
      event_valid <= 1'b1;
    end else if (event_ready) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign event_kind    = out_res.event_kind;
  assign command_code  = out_res.command_code;
  assign value_byte    = out_res.value_byte;
  assign length_total  = out_res.length_total;
  assign length_on     = out_res.length_on;
  assign length_off    = out_res.length_off;
  assign stream_ticks  = out_res.stream_ticks;
  assign stream_silent = out_res.stream_silent;

endmodule

FILE: src/mmlsed_core.sv
// parser state and per-byte decode of one channel command stream
module mmlsed_core import mmlsed_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic [7:0] item_byte,
  output logic       res_valid,
  output result_t    res
);

  phase_t      phase, phase_next;
  logic [1:0]  skip_left, skip_left_next;
  logic [7:0]  pending_opcode, pending_opcode_next;
  logic [6:0]  pending_key, pending_key_next;
  logic        pending_full, pending_full_next;
  logic [7:0]  gate_ratio, gate_ratio_next;
  logic [7:0]  default_length, default_length_next;
  logic [6:0]  last_key, last_key_next;
  logic [31:0] tick_sum, tick_sum_next;
  logic        silent_flag, silent_flag_next;

  logic [7:0]  total, prod8, prod_min, on_len, off_len;
  logic [12:0] prod;
  logic [32:0] sum_wide;
  logic        end_hit;

  // note length math
  always_comb begin
    total    = (item_byte != 8'd0) ? item_byte : default_length;
    prod     = 13'(total[7:3]) * 13'(gate_ratio);
    prod8    = prod[7:0];
    prod_min = (prod8 == 8'd0) ? 8'd1 : prod8;
    if (total == 8'd1) begin
      on_len = 8'd1;
    end else if (pending_full) begin
      on_len = total;
    end else if (gate_ratio == GATE_RESET) begin
      on_len = total - 8'd1;
    end else if (prod_min == total) begin
      on_len = prod_min - 8'd1;
    end else begin
      on_len = prod_min;
    end
    off_len  = total - on_len;
    sum_wide = {1'b0, tick_sum} + 33'(total);
  end

  assign end_hit = item_valid && (phase == PH_IDLE) && (item_byte == OP_END);

  always_comb begin
    phase_next          = phase;
    skip_left_next      = skip_left;
    pending_opcode_next = pending_opcode;
    pending_key_next    = pending_key;
    pending_full_next   = pending_full;
    gate_ratio_next     = gate_ratio;
    default_length_next = default_length;
    last_key_next       = last_key;
    tick_sum_next       = tick_sum;
    silent_flag_next    = silent_flag;
    res_valid           = 1'b0;
    res                 = '0;
    if (item_valid) begin
      case (phase)
        PH_SKIP: begin
          skip_left_next = skip_left - 2'd1;
          if (skip_left == 2'd1) begin
            phase_next = PH_IDLE;
          end
        end
        PH_ARG: begin
          phase_next = PH_IDLE;
          if (pending_opcode == OP_GATE) begin
            gate_ratio_next = item_byte + 8'd1;
          end else if (pending_opcode == OP_DEFLEN) begin
            default_length_next = item_byte;
          end else begin
            res_valid        = 1'b1;
            res.event_kind   = EV_PASS;
            res.command_code = pending_opcode;
            res.value_byte   = item_byte;
          end
        end
        PH_LEN: begin
          phase_next       = PH_IDLE;
          res_valid        = 1'b1;
          res.length_total = total;
          if (pending_key == KEY_REST7 || on_len == 8'd0) begin
            res.event_kind = EV_REST;
          end else begin
            res.event_kind   = EV_NOTE;
            res.value_byte   = {1'b0, pending_key};
            res.length_on    = on_len;
            res.length_off   = off_len;
            silent_flag_next = 1'b0;
          end
          tick_sum_next = sum_wide[32] ? TICKS_MAX : sum_wide[31:0];
        end
        default: begin
          case (item_byte)
            OP_END: begin
              res_valid           = 1'b1;
              res.event_kind      = EV_END;
              res.stream_ticks    = tick_sum;
              res.stream_silent   = silent_flag;
              phase_next          = PH_IDLE;
              skip_left_next      = 2'd0;
              pending_opcode_next = 8'd0;
              pending_key_next    = 7'd0;
              pending_full_next   = 1'b0;
              gate_ratio_next     = GATE_RESET;
              default_length_next = DEFLEN_RESET;
              last_key_next       = 7'd0;
              tick_sum_next       = 32'd0;
              silent_flag_next    = 1'b1;
            end
            OP_SKIP2_A, OP_SKIP2_B: begin
              skip_left_next = 2'd2;
              phase_next     = PH_SKIP;
            end
            OP_SKIP3_A, OP_SKIP3_B: begin
              skip_left_next = 2'd3;
              phase_next     = PH_SKIP;
            end
            OP_SKIP1_A, OP_SKIP1_B, OP_SKIP1_C, OP_SKIP1_D: begin
              skip_left_next = 2'd1;
              phase_next     = PH_SKIP;
            end
            OP_GATE, OP_DEFLEN, OP_TEMPO, OP_TONE, OP_VOLUME: begin
              pending_opcode_next = item_byte;
              phase_next          = PH_ARG;
            end
            OP_REPEAT: begin
              pending_key_next  = last_key;
              pending_full_next = 1'b0;
              phase_next        = PH_LEN;
            end
            default: begin
              if (item_byte <= KEY_MAX || item_byte == KEY_REST) begin
                pending_key_next  = item_byte[6:0];
                pending_full_next = 1'b0;
                last_key_next     = item_byte[6:0];
                phase_next        = PH_LEN;
              end else if (item_byte >= FULL_LO && item_byte <= FULL_HI) begin
                pending_key_next  = item_byte[6:0];
                pending_full_next = 1'b1;
                last_key_next     = item_byte[6:0];
                phase_next        = PH_LEN;
              end
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      skip_left      <= 2'd0;
      pending_opcode <= 8'd0;
      pending_key    <= 7'd0;
      pending_full   <= 1'b0;
      gate_ratio     <= GATE_RESET;
      default_length <= DEFLEN_RESET;
      last_key       <= 7'd0;
      tick_sum       <= 32'd0;
      silent_flag    <= 1'b1;
    end else begin
      phase          <= phase_next;
      skip_left      <= skip_left_next;
      pending_opcode <= pending_opcode_next;
      pending_key    <= pending_key_next;
      pending_full   <= pending_full_next;
      gate_ratio     <= gate_ratio_next;
      default_length <= default_length_next;
      last_key       <= last_key_next;
      tick_sum       <= tick_sum_next;
      silent_flag    <= silent_flag_next;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    end_hit |=> (tick_sum == 32'd0 && silent_flag && phase == PH_IDLE))
    else $error("end item did not clear stream state");

  a_note_split: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.event_kind == EV_NOTE) |->
      (8'(res.length_on + res.length_off) == res.length_total))
    else $error("note on and off do not add up to total");

  a_silent_rise: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(silent_flag)) |-> $past(end_hit))
    else $error("silent flag set without end item");

  a_skip_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SKIP) |-> (skip_left != 2'd0))
    else $error("skip phase with no bytes left");

endmodule

FILE: tb/sv/mml_sequence_event_decoder_test.sv
// self-checking testbench of the sequence event decoder with its own byte-stream predictor
`timescale 1ns / 1ps

module mml_sequence_event_decoder_test;
  import mmlsed_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int BYTES_PER_PHASE = 460;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        stream_valid = 1'b0;
  logic        stream_ready;
  logic [7:0]  stream_byte = 8'h00;
  logic        event_valid;
  logic        event_ready = 1'b0;
  logic [1:0]  event_kind;
  logic [7:0]  command_code;
  logic [7:0]  value_byte;
  logic [7:0]  length_total;
  logic [7:0]  length_on;
  logic [7:0]  length_off;
  logic [31:0] stream_ticks;
  logic        stream_silent;

  mml_sequence_event_decoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .stream_valid (stream_valid),
    .stream_ready (stream_ready),
    .stream_byte  (stream_byte),
    .event_valid  (event_valid),
    .event_ready  (event_ready),
    .event_kind   (event_kind),
    .command_code (command_code),
    .value_byte   (value_byte),
    .length_total (length_total),
    .length_on    (length_on),
    .length_off   (length_off),
    .stream_ticks (stream_ticks),
    .stream_silent(stream_silent)
  );

  phase_t      parse_phase;
  logic [1:0]  skip_left;
  logic [7:0]  pending_opcode;
  logic [6:0]  pending_key;
  logic        pending_full;
  logic [7:0]  gate_ratio;
  logic [7:0]  default_length;
  logic [6:0]  last_key;
  logic [31:0] tick_sum;
  logic        silent_flag;

  logic [7:0]  stream_backlog[$];
  result_t     events_due[$];
  int          bytes_queued = 0;
  int          bytes_taken = 0;
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        byte_taken = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic reset_parser();
    parse_phase = PH_IDLE;
    skip_left = 2'd0;
    pending_opcode = 8'h00;
    pending_key = 7'h00;
    pending_full = 1'b0;
    gate_ratio = GATE_RESET;
    default_length = DEFLEN_RESET;
    last_key = 7'h00;
    tick_sum = 32'd0;
    silent_flag = 1'b1;
  endtask

  task automatic finish_note(input logic [7:0] len_byte);
    result_t    r;
    logic [7:0] total;
    logic [7:0] on_ticks;
    r = '0;
    total = (len_byte != 8'd0) ? len_byte : default_length;
    if (total == 8'd1) begin
      on_ticks = 8'd1;
    end else if (pending_full) begin
      on_ticks = total;
    end else if (gate_ratio == GATE_RESET) begin
      on_ticks = total - 8'd1;
    end else begin
      on_ticks = (total >> 3) * gate_ratio;
      if (on_ticks == 8'd0) on_ticks = 8'd1;
      if (on_ticks == total) on_ticks = on_ticks - 8'd1;
    end
    r.length_total = total;
    if (pending_key == KEY_REST7 || on_ticks == 8'd0) begin
      r.event_kind = EV_REST;
    end else begin
      r.event_kind = EV_NOTE;
      r.value_byte = {1'b0, pending_key};
      r.length_on = on_ticks;
      r.length_off = total - on_ticks;
      silent_flag = 1'b0;
    end
    if (tick_sum > TICKS_MAX - {24'd0, total}) tick_sum = TICKS_MAX;
    else tick_sum = tick_sum + {24'd0, total};
    events_due.push_back(r);
  endtask

  task automatic decode_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    case (parse_phase)
      PH_SKIP: begin
        skip_left = skip_left - 2'd1;
        if (skip_left == 2'd0) parse_phase = PH_IDLE;
      end
      PH_ARG: begin
        parse_phase = PH_IDLE;
        if (pending_opcode == OP_GATE) begin
          gate_ratio = b + 8'd1;
        end else if (pending_opcode == OP_DEFLEN) begin
          default_length = b;
        end else begin
          r.event_kind = EV_PASS;
          r.command_code = pending_opcode;
          r.value_byte = b;
          events_due.push_back(r);
        end
      end
      PH_LEN: begin
        parse_phase = PH_IDLE;
        finish_note(b);
      end
      default: begin
        if (b == OP_END) begin
          r.event_kind = EV_END;
          r.stream_ticks = tick_sum;
          r.stream_silent = silent_flag;
          events_due.push_back(r);
          reset_parser();
        end else begin
          case (b)
            OP_SKIP2_A, OP_SKIP2_B: begin
              skip_left = 2'd2;
              parse_phase = PH_SKIP;
            end
            OP_SKIP3_A, OP_SKIP3_B: begin
              skip_left = 2'd3;
              parse_phase = PH_SKIP;
            end
            OP_SKIP1_A, OP_SKIP1_B, OP_SKIP1_C, OP_SKIP1_D: begin
              skip_left = 2'd1;
              parse_phase = PH_SKIP;
            end
            OP_GATE, OP_DEFLEN, OP_TEMPO, OP_TONE, OP_VOLUME: begin
              pending_opcode = b;
              parse_phase = PH_ARG;
            end
            OP_REPEAT: begin
              pending_key = last_key;
              pending_full = 1'b0;
              parse_phase = PH_LEN;
            end
            default: begin
              if (b <= KEY_MAX || b == KEY_REST) begin
                pending_key = b[6:0];
                pending_full = 1'b0;
                last_key = b[6:0];
                parse_phase = PH_LEN;
              end else if (b >= FULL_LO && b <= FULL_HI) begin
                pending_key = b[6:0];
                pending_full = 1'b1;
                last_key = b[6:0];
                parse_phase = PH_LEN;
              end
            end
          endcase
        end
      end
    endcase
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] wanted);
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, wanted, $time);
    mismatches++;
  endtask

  task automatic check_event();
    result_t want;
    if (events_due.size() == 0) begin
      flag_mismatch("unexpected event kind", {30'd0, event_kind}, 32'd0);
      return;
    end
    want = events_due.pop_front();
    if (event_kind !== want.event_kind)
      flag_mismatch("event_kind", {30'd0, event_kind}, {30'd0, want.event_kind});
    if (command_code !== want.command_code)
      flag_mismatch("command_code", {24'd0, command_code}, {24'd0, want.command_code});
    if (value_byte !== want.value_byte)
      flag_mismatch("value_byte", {24'd0, value_byte}, {24'd0, want.value_byte});
    if (length_total !== want.length_total)
      flag_mismatch("length_total", {24'd0, length_total}, {24'd0, want.length_total});
    if (length_on !== want.length_on)
      flag_mismatch("length_on", {24'd0, length_on}, {24'd0, want.length_on});
    if (length_off !== want.length_off)
      flag_mismatch("length_off", {24'd0, length_off}, {24'd0, want.length_off});
    if (stream_ticks !== want.stream_ticks)
      flag_mismatch("stream_ticks", stream_ticks, want.stream_ticks);
    if (stream_silent !== want.stream_silent)
      flag_mismatch("stream_silent", {31'd0, stream_silent}, {31'd0, want.stream_silent});
  endtask

  task automatic queue_byte(input logic [7:0] b);
    stream_backlog.push_back(b);
    bytes_queued++;
  endtask

  function automatic logic [7:0] pick_length();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd1;
    if (r == 2) return 8'hFF;
    if (r < 6) return 8'($urandom_range(2, 40));
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 8'($urandom_range(0, KEY_MAX));
    if (r < 55) return KEY_REST;
    return 8'($urandom_range(FULL_LO, FULL_HI));
  endfunction

  task automatic queue_command();
    int         r;
    int         n;
    logic [7:0] op;
    r = $urandom_range(99);
    if (r < 45) begin
      queue_byte(pick_key());
      queue_byte(pick_length());
    end else if (r < 55) begin
      queue_byte(OP_REPEAT);
      queue_byte(pick_length());
    end else if (r < 62) begin
      queue_byte(OP_GATE);
      case ($urandom_range(3))
        0: queue_byte(8'd7);
        1: queue_byte(8'hFF);
        2: queue_byte(8'($urandom_range(0, 15)));
        default: queue_byte(8'($urandom));
      endcase
    end else if (r < 68) begin
      queue_byte(OP_DEFLEN);
      queue_byte(pick_length());
    end else if (r < 78) begin
      case ($urandom_range(2))
        0: queue_byte(OP_TEMPO);
        1: queue_byte(OP_TONE);
        default: queue_byte(OP_VOLUME);
      endcase
      queue_byte(8'($urandom));
    end else if (r < 88) begin
      case ($urandom_range(7))
        0: begin op = OP_SKIP2_A; n = 2; end
        1: begin op = OP_SKIP2_B; n = 2; end
        2: begin op = OP_SKIP3_A; n = 3; end
        3: begin op = OP_SKIP3_B; n = 3; end
        4: begin op = OP_SKIP1_A; n = 1; end
        5: begin op = OP_SKIP1_B; n = 1; end
        6: begin op = OP_SKIP1_C; n = 1; end
        default: begin op = OP_SKIP1_D; n = 1; end
      endcase
      queue_byte(op);
      repeat (n) queue_byte(($urandom_range(3) == 0) ? OP_END : 8'($urandom));
    end else if (r < 93) begin
      case ($urandom_range(2))
        0: queue_byte(8'($urandom_range(8'h61, 8'h6F)));
        1: queue_byte(8'($urandom_range(8'h71, 8'h7F)));
        default: queue_byte(8'($urandom_range(8'hE1, 8'hF0)));
      endcase
    end else if (r < 96) begin
      queue_byte(OP_END);
    end else begin
      queue_byte(8'($urandom));
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      stream_valid <= 1'b0;
    end else if (stream_valid && !byte_taken) begin
      stream_valid <= 1'b1;
    end else if (stream_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      stream_byte <= stream_backlog.pop_front();
      stream_valid <= 1'b1;
    end else begin
      stream_byte <= 8'($urandom);
      stream_valid <= 1'b0;
    end
    event_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    byte_taken = stream_valid && stream_ready;
    if (!rst) begin
      if (event_valid && event_ready) check_event();
      if (byte_taken) begin
        decode_byte(stream_byte);
        bytes_taken++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (stream_valid && stream_ready) || (event_valid && event_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("mml_sequence_event_decoder_test failed");
      $finish;
    end
  end

  initial begin
    int phase_start;
    reset_parser();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 83; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 83; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      phase_start = bytes_queued;
      if (ph == 0) begin
        queue_byte(OP_END);
        queue_byte(8'h00); queue_byte(8'h00);
        queue_byte(KEY_MAX); queue_byte(8'd1);
        queue_byte(KEY_REST); queue_byte(8'hFF);
        queue_byte(FULL_HI); queue_byte(8'h00);
        queue_byte(OP_REPEAT); queue_byte(8'hFF);
        queue_byte(OP_GATE); queue_byte(8'hFF);
        queue_byte(8'h10); queue_byte(8'h10);
        queue_byte(OP_DEFLEN); queue_byte(8'h00);
        queue_byte(8'h20); queue_byte(8'h00);
        queue_byte(OP_TEMPO); queue_byte(8'hFF);
        queue_byte(OP_TONE); queue_byte(8'h00);
        queue_byte(OP_VOLUME); queue_byte(8'h80);
        queue_byte(OP_SKIP3_A); queue_byte(8'hFF); queue_byte(8'hFF); queue_byte(8'hFF);
        queue_byte(8'h7F);
        queue_byte(OP_END);
      end
      while (bytes_queued - phase_start < BYTES_PER_PHASE) queue_command();
      queue_byte(OP_END);
      while (bytes_taken != bytes_queued) @(posedge clk);
    end

    while (events_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) $display("mml_sequence_event_decoder_test passed");
    else $display("mml_sequence_event_decoder_test failed");
    $finish;
  end

endmodule
